>>> hdl/imbsm_pkg.sv
// imbsm_pkg: shared types, decode constants and clamp helpers for the
// indexed bank switch mapper; no dependencies
package imbsm_pkg;

   localparam logic [15:0] ADDR_MASK     = 16'hE001;
   localparam logic [15:0] ADDR_INDEX    = 16'h8000;
   localparam logic [15:0] ADDR_BANK     = 16'hA000;
   localparam logic [15:0] ADDR_CHR_HIGH = 16'hC000;
   localparam logic [15:0] ADDR_CONTROL  = 16'hE000;

   localparam logic [2:0] IDX_PRG_LO = 3'd0;
   localparam logic [2:0] IDX_PRG_HI = 3'd1;
   localparam logic [2:0] IDX_CHR_2K_A = 3'd2;
   localparam logic [2:0] IDX_CHR_2K_B = 3'd3;

   // bank_registers slots reused for the high-bit and control registers
   localparam int REG_CHR_HIGH = 0;
   localparam int REG_CONTROL  = 1;

   localparam int CTRL_MIRROR   = 0;
   localparam int CTRL_HIGH_ENA = 1;

   localparam logic [1:0] CSR_PRG_BANK_MAX = 2'd0;
   localparam logic [1:0] CSR_CHR_2K_MAX   = 2'd1;
   localparam logic [1:0] CSR_CHR_1K_MAX   = 2'd2;

   localparam logic [7:0] PRG_BANK_MAX_RST = 8'd255;
   localparam logic [7:0] CHR_2K_MAX_RST   = 8'd255;
   localparam logic [8:0] CHR_1K_MAX_RST   = 9'd511;

   typedef struct packed {
      logic [2:0]      register_index;
      logic [7:0][7:0] bank_registers;
      logic [7:0]      prg_lo;
      logic [7:0]      prg_hi;
   } bank_state_type;

   typedef struct packed {
      logic [7:0]      prg_bank_lo;
      logic [7:0]      prg_bank_hi;
      logic [7:0][8:0] chr_slot;
      logic            mirror_horizontal;
   } mapping_type;

   function automatic logic [7:0] clamp8(input logic [7:0] v, input logic [7:0] max);
      clamp8 = (v > max) ? (v & max) : v;
   endfunction

   function automatic logic [8:0] clamp9(input logic [8:0] v, input logic [8:0] max);
      clamp9 = (v > max) ? (v & max) : v;
   endfunction

endpackage

>>> hdl/indexed_bank_switch_mapper.sv
// Indexed bank switch mapper: decodes one cpu write per request (address mask
// 0xE001) and returns the full prg/chr bank mapping and mirroring after it.
// Two register stages (request register, result register); one request per
// cycle while no response is held back; rsp_valid rises as the mapping is
// loaded into the result register. Uses imbsm_pkg, imbsm_regs and imbsm_map.
module indexed_bank_switch_mapper (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_cpu_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_prg_bank_lo,
   output logic [7:0]  rsp_prg_bank_hi,
   output logic [8:0]  rsp_chr_slot_0,
   output logic [8:0]  rsp_chr_slot_1,
   output logic [8:0]  rsp_chr_slot_2,
   output logic [8:0]  rsp_chr_slot_3,
   output logic [8:0]  rsp_chr_slot_4,
   output logic [8:0]  rsp_chr_slot_5,
   output logic [8:0]  rsp_chr_slot_6,
   output logic [8:0]  rsp_chr_slot_7,
   output logic        rsp_mirror_horizontal,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata
);
   import imbsm_pkg::*;

   logic        req_valid_ff, req_valid_in;
   logic [15:0] address_ff;
   logic [7:0]  data_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   mapping_type rsp_ff;
   logic [7:0]  prg_bank_max_ff;
   logic [7:0]  chr_2k_max_ff;
   logic [8:0]  chr_1k_max_ff;

   logic           advance;
   logic           req_take;
   bank_state_type state_next;
   mapping_type    mapping;

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   imbsm_regs u_regs (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .address      (address_ff),
      .data         (data_ff),
      .prg_bank_max (prg_bank_max_ff),
      .state_next   (state_next)
   );

   imbsm_map u_map (
      .state      (state_next),
      .chr_2k_max (chr_2k_max_ff),
      .chr_1k_max (chr_1k_max_ff),
      .mapping    (mapping)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         prg_bank_max_ff <= PRG_BANK_MAX_RST;
         chr_2k_max_ff   <= CHR_2K_MAX_RST;
         chr_1k_max_ff   <= CHR_1K_MAX_RST;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_PRG_BANK_MAX: prg_bank_max_ff <= csr_wdata[7:0];
               CSR_CHR_2K_MAX:   chr_2k_max_ff   <= csr_wdata[7:0];
               CSR_CHR_1K_MAX:   chr_1k_max_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         address_ff <= req_cpu_address;
         data_ff    <= req_write_data;
      end
      if (advance) begin
         rsp_ff <= mapping;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_prg_bank_lo       = rsp_ff.prg_bank_lo;
   assign rsp_prg_bank_hi       = rsp_ff.prg_bank_hi;
   assign rsp_chr_slot_0        = rsp_ff.chr_slot[0];
   assign rsp_chr_slot_1        = rsp_ff.chr_slot[1];
   assign rsp_chr_slot_2        = rsp_ff.chr_slot[2];
   assign rsp_chr_slot_3        = rsp_ff.chr_slot[3];
   assign rsp_chr_slot_4        = rsp_ff.chr_slot[4];
   assign rsp_chr_slot_5        = rsp_ff.chr_slot[5];
   assign rsp_chr_slot_6        = rsp_ff.chr_slot[6];
   assign rsp_chr_slot_7        = rsp_ff.chr_slot[7];
   assign rsp_mirror_horizontal = rsp_ff.mirror_horizontal;

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (req_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("request stage stalled without a full pipeline");

   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced request produced no response");

   a_2k_slot_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_chr_slot_0[0] == 1'b0 && rsp_chr_slot_1 == (rsp_chr_slot_0 | 9'd1)
                     && rsp_chr_slot_3 == (rsp_chr_slot_2 | 9'd1)))
      else $error("2k chr slot pair is not even/odd");

endmodule

>>> hdl/imbsm_regs.sv
// imbsm_regs: write decoder and bank register state
// uses imbsm_pkg; next state is committed when the request advances
module imbsm_regs (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [15:0]                  address,
   input  logic [7:0]                   data,
   input  logic [7:0]                   prg_bank_max,
   output imbsm_pkg::bank_state_type    state_next
);
   import imbsm_pkg::*;

   bank_state_type state_ff;
   bank_state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (address & ADDR_MASK)
         ADDR_INDEX: begin
            state_in.register_index = data[2:0];
         end
         ADDR_BANK: begin
            case (state_ff.register_index) inside
               IDX_PRG_LO: state_in.prg_lo = clamp8(data, prg_bank_max);
               IDX_PRG_HI: state_in.prg_hi = clamp8(data, prg_bank_max);
               IDX_CHR_2K_A, IDX_CHR_2K_B: begin
                  state_in.bank_registers[state_ff.register_index] = {1'b0, data[7:1]};
               end
               default: state_in.bank_registers[state_ff.register_index] = data;
            endcase
         end
         ADDR_CHR_HIGH: state_in.bank_registers[REG_CHR_HIGH] = data;
         ADDR_CONTROL:  state_in.bank_registers[REG_CONTROL] = data;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   assign state_next = state_in;

endmodule

>>> hdl/imbsm_map.sv
// imbsm_map: forms prg banks, eight 1k chr slots and mirroring from bank state
// uses imbsm_pkg
module imbsm_map (
   input  imbsm_pkg::bank_state_type state,
   input  logic [7:0]                chr_2k_max,
   input  logic [8:0]                chr_1k_max,
   output imbsm_pkg::mapping_type    mapping
);
   import imbsm_pkg::*;

   logic [7:0] hi;
   logic [7:0] bank_a;
   logic [7:0] bank_b;

   always_comb begin
      hi = state.bank_registers[REG_CONTROL][CTRL_HIGH_ENA] ?
           state.bank_registers[REG_CHR_HIGH] : 8'd0;
      bank_a = clamp8({hi[2], state.bank_registers[2][6:0]} |
                      {1'b0, state.bank_registers[2][6:0]} |
                      {state.bank_registers[2][7], 7'd0}, chr_2k_max);
      bank_b = clamp8({hi[3] | state.bank_registers[3][7], state.bank_registers[3][6:0]},
                      chr_2k_max);

      mapping.prg_bank_lo = state.prg_lo;
      mapping.prg_bank_hi = state.prg_hi;
      mapping.chr_slot[0] = {bank_a, 1'b0};
      mapping.chr_slot[1] = {bank_a, 1'b1};
      mapping.chr_slot[2] = {bank_b, 1'b0};
      mapping.chr_slot[3] = {bank_b, 1'b1};
      mapping.chr_slot[4] = clamp9({hi[4], state.bank_registers[4]}, chr_1k_max);
      mapping.chr_slot[5] = clamp9({hi[5], state.bank_registers[5]}, chr_1k_max);
      mapping.chr_slot[6] = clamp9({hi[6], state.bank_registers[6]}, chr_1k_max);
      mapping.chr_slot[7] = clamp9({hi[7], state.bank_registers[7]}, chr_1k_max);
      mapping.mirror_horizontal = state.bank_registers[REG_CONTROL][CTRL_MIRROR];
   end

endmodule
